[rtl/disparity_to_point_reprojection_unit_assert.svh]
// Assertion macros used by the checker file drp_checker.sv.
`ifndef DISPARITY_TO_POINT_REPROJECTION_UNIT_ASSERT_SVH
`define DISPARITY_TO_POINT_REPROJECTION_UNIT_ASSERT_SVH

// Checked on every edge, reset included.
`define DRP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

// Checked outside reset only.
`define DRP_ASSERT_RUN(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`endif

[rtl/drp_pkg.sv]
`default_nettype none
package drp_pkg;

  localparam int COORD_BITS_DEF    = 12;
  localparam int OUT_FRAC_BITS_DEF = 16;

  localparam int BASE_FRAC    = 28;
  localparam int SUBPIX_SHIFT = 4;
  localparam int IN_FRAC      = 8;
  // quotients at or above 2^SAT_SHIFT saturate
  localparam int SAT_SHIFT    = 31;
  localparam int Q_W          = SAT_SHIFT;
  localparam int B_W          = 48;

  typedef enum logic [2:0] {
    REG_OFFSET_X     = 3'd0,
    REG_OFFSET_Y     = 3'd1,
    REG_FOCAL_LENGTH = 3'd2,
    REG_INV_BASELINE = 3'd3,
    REG_SUBPIXEL     = 3'd4,
    REG_USE_PIXEL    = 3'd5,
    REG_FIXED_COLOUR = 3'd6,
    REG_SPARE        = 3'd7
  } reg_index_t;

  typedef struct packed {
    logic [23:0] offset_x;
    logic [23:0] offset_y;
    logic [23:0] focal_length;
    logic [31:0] inverse_baseline;
    logic        subpixel_mode;
    logic        use_pixel_colour;
    logic [23:0] fixed_colour;
  } cfg_t;

  // sideband that travels with each beat down the divider row
  typedef struct packed {
    logic        valid;
    logic        xneg;
    logic        yneg;
    logic        zneg;
    logic        xsat;
    logic        ysat;
    logic        zsat;
    logic [23:0] colour;
  } meta_t;

endpackage
`default_nettype wire

[rtl/drp_front.sv]
`default_nettype none
module drp_front #(
  parameter int COORD_BITS    = 12,
  parameter int OUT_FRAC_BITS = 16,
  parameter int NA            = 25,
  parameter int RW            = 79
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire drp_pkg::cfg_t cfg,
  input  wire logic          accept,
  input  wire logic [15:0]   disparity,
  input  wire logic          pixel_valid,
  input  wire logic [11:0]   column,
  input  wire logic [11:0]   image_row,
  input  wire logic [7:0]    red_in,
  input  wire logic [7:0]    green_in,
  input  wire logic [7:0]    blue_in,
  output drp_pkg::meta_t     meta_o,
  output logic [RW-1:0]      rem_x_o,
  output logic [RW-1:0]      rem_y_o,
  output logic [RW-1:0]      rem_z_o,
  output logic [drp_pkg::B_W-1:0] b_o
);
  import drp_pkg::*;

  localparam int S1 = BASE_FRAC + SUBPIX_SHIFT + OUT_FRAC_BITS - IN_FRAC;
  localparam int S0 = BASE_FRAC + OUT_FRAC_BITS - IN_FRAC;

  // stage a
  logic              valid_a;
  logic              wneg_a;
  logic [31:0]       ibmag_a;
  logic [15:0]       disp_a;
  logic signed [NA:0] nx_a, ny_a;
  logic [23:0]       colour_a;
  // stage b
  logic              valid_b;
  logic              xneg_b, yneg_b, zneg_b;
  logic [NA-1:0]     ax_b, ay_b;
  logic [23:0]       az_b;
  logic [B_W-1:0]    wmag_b;
  logic [23:0]       colour_b;

  logic [11:0]       colm, rowm;
  logic signed [NA:0] nx_next, ny_next;
  logic [RW-1:0]     dx, dy, dz, thr;

  assign colm = column & 12'((1 << COORD_BITS) - 1);
  assign rowm = image_row & 12'((1 << COORD_BITS) - 1);
  assign nx_next = $signed({{(NA - 19){1'b0}}, colm, 8'b0})
                 + $signed({{(NA - 23){cfg.offset_x[23]}}, cfg.offset_x});
  assign ny_next = $signed({{(NA - 19){1'b0}}, rowm, 8'b0})
                 + $signed({{(NA - 23){cfg.offset_y[23]}}, cfg.offset_y});

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_a <= 1'b0;
    end else begin
      valid_a <= accept && pixel_valid;
    end
    wneg_a  <= cfg.inverse_baseline[31];
    ibmag_a <= cfg.inverse_baseline[31] ? (32'd0 - cfg.inverse_baseline)
                                        : cfg.inverse_baseline;
    disp_a  <= disparity;
    nx_a    <= nx_next;
    ny_a    <= ny_next;
    colour_a <= cfg.use_pixel_colour ? {red_in, green_in, blue_in} : cfg.fixed_colour;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_b <= 1'b0;
    end else begin
      valid_b <= valid_a;
    end
    xneg_b   <= nx_a[NA] ^ wneg_a;
    yneg_b   <= ny_a[NA] ^ wneg_a;
    zneg_b   <= wneg_a;
    ax_b     <= nx_a[NA] ? NA'(-nx_a) : NA'(nx_a);
    ay_b     <= ny_a[NA] ? NA'(-ny_a) : NA'(ny_a);
    az_b     <= cfg.focal_length;
    wmag_b   <= B_W'(ibmag_a * disp_a);
    colour_b <= colour_a;
  end

  assign dx  = cfg.subpixel_mode ? (RW'(ax_b) << S1) : (RW'(ax_b) << S0);
  assign dy  = cfg.subpixel_mode ? (RW'(ay_b) << S1) : (RW'(ay_b) << S0);
  assign dz  = cfg.subpixel_mode ? (RW'(az_b) << S1) : (RW'(az_b) << S0);
  assign thr = RW'(wmag_b) << SAT_SHIFT;

  always_ff @(posedge clk) begin
    if (rst) begin
      meta_o.valid <= 1'b0;
    end else begin
      // w of zero gives no point
      meta_o.valid <= valid_b && (wmag_b != '0);
    end
    meta_o.xneg   <= xneg_b;
    meta_o.yneg   <= yneg_b;
    meta_o.zneg   <= zneg_b;
    meta_o.xsat   <= dx >= thr;
    meta_o.ysat   <= dy >= thr;
    meta_o.zsat   <= dz >= thr;
    meta_o.colour <= colour_b;
    rem_x_o <= dx;
    rem_y_o <= dy;
    rem_z_o <= dz;
    b_o     <= wmag_b;
  end

endmodule
`default_nettype wire

[rtl/drp_div_cell.sv]
`default_nettype none
module drp_div_cell #(
  parameter int RW = 79,
  parameter int K  = 30
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire drp_pkg::meta_t         meta_i,
  input  wire logic [RW-1:0]          rem_x_i,
  input  wire logic [RW-1:0]          rem_y_i,
  input  wire logic [RW-1:0]          rem_z_i,
  input  wire logic [drp_pkg::Q_W-1:0] q_x_i,
  input  wire logic [drp_pkg::Q_W-1:0] q_y_i,
  input  wire logic [drp_pkg::Q_W-1:0] q_z_i,
  input  wire logic [drp_pkg::B_W-1:0] b_i,
  output drp_pkg::meta_t              meta_o,
  output logic [RW-1:0]               rem_x_o,
  output logic [RW-1:0]               rem_y_o,
  output logic [RW-1:0]               rem_z_o,
  output logic [drp_pkg::Q_W-1:0]     q_x_o,
  output logic [drp_pkg::Q_W-1:0]     q_y_o,
  output logic [drp_pkg::Q_W-1:0]     q_z_o,
  output logic [drp_pkg::B_W-1:0]     b_o
);
  import drp_pkg::*;

  logic [RW-1:0] trial;
  logic ge_x, ge_y, ge_z;

  // one restoring step per lane: quotient bit K
  assign trial = RW'(b_i) << K;
  assign ge_x  = rem_x_i >= trial;
  assign ge_y  = rem_y_i >= trial;
  assign ge_z  = rem_z_i >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      meta_o.valid <= 1'b0;
    end else begin
      meta_o.valid <= meta_i.valid;
    end
    meta_o.xneg   <= meta_i.xneg;
    meta_o.yneg   <= meta_i.yneg;
    meta_o.zneg   <= meta_i.zneg;
    meta_o.xsat   <= meta_i.xsat;
    meta_o.ysat   <= meta_i.ysat;
    meta_o.zsat   <= meta_i.zsat;
    meta_o.colour <= meta_i.colour;
    rem_x_o <= ge_x ? rem_x_i - trial : rem_x_i;
    rem_y_o <= ge_y ? rem_y_i - trial : rem_y_i;
    rem_z_o <= ge_z ? rem_z_i - trial : rem_z_i;
    q_x_o   <= q_x_i | (Q_W'(ge_x) << K);
    q_y_o   <= q_y_i | (Q_W'(ge_y) << K);
    q_z_o   <= q_z_i | (Q_W'(ge_z) << K);
    b_o     <= b_i;
  end

endmodule
`default_nettype wire

[rtl/disparity_to_point_reprojection_unit.sv]
`default_nettype none
// channel   ports                                        handshake
// config    cfg_index, cfg_data                          cfg_write
// pixel     disparity, pixel_valid, column, image_row,   start & !busy
//           red_in, green_in, blue_in
// point     point_x/y/z, red_out, green_out, blue_out    done, one cycle
//
// One pixel a cycle through three front stages (offset add, 32x16
// multiply of w, scaling and saturation compare), 31 divider cells
// giving one quotient bit each, and one output stage.
// busy is high only in reset; rst clears all valid bits.
// The receiver cannot stall; masked pixels and w of zero leave gaps.
module disparity_to_point_reprojection_unit #(
  parameter int COORD_BITS    = drp_pkg::COORD_BITS_DEF,
  parameter int OUT_FRAC_BITS = drp_pkg::OUT_FRAC_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_write,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [15:0] disparity,
  input  wire logic        pixel_valid,
  input  wire logic [11:0] column,
  input  wire logic [11:0] image_row,
  input  wire logic [7:0]  red_in,
  input  wire logic [7:0]  green_in,
  input  wire logic [7:0]  blue_in,
  output logic             done,
  output logic [31:0]      point_x,
  output logic [31:0]      point_y,
  output logic [31:0]      point_z,
  output logic [7:0]       red_out,
  output logic [7:0]       green_out,
  output logic [7:0]       blue_out
);
  import drp_pkg::*;

  localparam int NA   = ((COORD_BITS + IN_FRAC > 24) ? COORD_BITS + IN_FRAC : 24) + 1;
  localparam int SMAX = BASE_FRAC + SUBPIX_SHIFT + OUT_FRAC_BITS - IN_FRAC;
  localparam int RW   = (NA + SMAX > B_W + SAT_SHIFT) ? NA + SMAX : B_W + SAT_SHIFT;

  cfg_t cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.offset_x         <= '0;
      cfg.offset_y         <= '0;
      cfg.focal_length     <= '0;
      cfg.inverse_baseline <= '0;
      cfg.subpixel_mode    <= 1'b1;
      cfg.use_pixel_colour <= 1'b1;
      cfg.fixed_colour     <= '0;
    end else if (cfg_write) begin
      case (reg_index_t'(cfg_index))
        REG_OFFSET_X:     cfg.offset_x         <= cfg_data[23:0];
        REG_OFFSET_Y:     cfg.offset_y         <= cfg_data[23:0];
        REG_FOCAL_LENGTH: cfg.focal_length     <= cfg_data[23:0];
        REG_INV_BASELINE: cfg.inverse_baseline <= cfg_data;
        REG_SUBPIXEL:     cfg.subpixel_mode    <= cfg_data[0];
        REG_USE_PIXEL:    cfg.use_pixel_colour <= cfg_data[0];
        REG_FIXED_COLOUR: cfg.fixed_colour     <= cfg_data[23:0];
        default: ;
      endcase
    end
  end

  assign busy = rst;

  meta_t         meta [Q_W+1];
  logic [RW-1:0] rx [Q_W+1];
  logic [RW-1:0] ry [Q_W+1];
  logic [RW-1:0] rz [Q_W+1];
  logic [Q_W-1:0] qx [Q_W+1];
  logic [Q_W-1:0] qy [Q_W+1];
  logic [Q_W-1:0] qz [Q_W+1];
  logic [B_W-1:0] bb [Q_W+1];

  drp_front #(
    .COORD_BITS(COORD_BITS), .OUT_FRAC_BITS(OUT_FRAC_BITS), .NA(NA), .RW(RW)
  ) u_front (
    .clk(clk), .rst(rst), .cfg(cfg), .accept(start && !busy),
    .disparity(disparity), .pixel_valid(pixel_valid), .column(column),
    .image_row(image_row), .red_in(red_in), .green_in(green_in), .blue_in(blue_in),
    .meta_o(meta[0]), .rem_x_o(rx[0]), .rem_y_o(ry[0]), .rem_z_o(rz[0]), .b_o(bb[0])
  );

  assign qx[0] = '0;
  assign qy[0] = '0;
  assign qz[0] = '0;

  for (genvar i = 0; i < Q_W; i++) begin : g_cell
    drp_div_cell #(.RW(RW), .K(Q_W - 1 - i)) u_cell (
      .clk(clk), .rst(rst),
      .meta_i(meta[i]), .rem_x_i(rx[i]), .rem_y_i(ry[i]), .rem_z_i(rz[i]),
      .q_x_i(qx[i]), .q_y_i(qy[i]), .q_z_i(qz[i]), .b_i(bb[i]),
      .meta_o(meta[i+1]), .rem_x_o(rx[i+1]), .rem_y_o(ry[i+1]), .rem_z_o(rz[i+1]),
      .q_x_o(qx[i+1]), .q_y_o(qy[i+1]), .q_z_o(qz[i+1]), .b_o(bb[i+1])
    );
  end

  function automatic logic [31:0] fix_sign(logic [Q_W-1:0] q, logic neg, logic sat);
    logic [31:0] mag;
    mag = sat ? 32'h8000_0000 : 32'(q);
    if (neg) begin
      return 32'd0 - mag;
    end else begin
      return sat ? 32'h7FFF_FFFF : mag;
    end
  endfunction

  meta_t m_last;
  assign m_last = meta[Q_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= m_last.valid;
    end
    point_x   <= fix_sign(qx[Q_W], m_last.xneg, m_last.xsat);
    point_y   <= fix_sign(qy[Q_W], m_last.yneg, m_last.ysat);
    point_z   <= fix_sign(qz[Q_W], m_last.zneg, m_last.zsat);
    red_out   <= m_last.colour[23:16];
    green_out <= m_last.colour[15:8];
    blue_out  <= m_last.colour[7:0];
  end

endmodule
`default_nettype wire

[rtl/drp_checker.sv]
`default_nettype none
`include "disparity_to_point_reprojection_unit_assert.svh"
module drp_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        start,
  input wire logic        busy,
  input wire logic        pixel_valid,
  input wire logic        done
);

  // pipeline flushed by reset
  `DRP_ASSERT(a_flush, rst |=> !done, "point beat right after reset")
  // pixels are never refused outside reset
  `DRP_ASSERT(a_ready, !rst |-> !busy, "busy outside reset")
  // every point stems from an accepted, unmasked pixel
  `DRP_ASSERT_RUN(a_origin, done |-> $past(start && !busy && pixel_valid, 35),
                  "point without matching pixel")

endmodule

bind disparity_to_point_reprojection_unit drp_checker u_drp_checker (.*);
`default_nettype wire
